// File: hdl/plob_pkg.sv
// shared constants, level record and memory access types for the price level order book
// used by plob_level_store and price_level_order_book_unit; no dependencies
`default_nettype none

package plob_pkg;

   localparam int NUM_SYMBOLS = 8;
   localparam int SIDE_DEPTH  = 16;

   localparam int NUM_SIDES   = NUM_SYMBOLS * 2;
   localparam int NUM_ENTRIES = NUM_SIDES * SIDE_DEPTH;
   localparam int SIDX_W      = $clog2(NUM_SIDES);
   localparam int ADDR_W      = $clog2(NUM_ENTRIES);
   localparam int CNT_W       = $clog2(SIDE_DEPTH + 1);
   localparam int TOT_W       = $clog2(2 * SIDE_DEPTH + 1);

   // field widths and stream packing
   localparam int SYM_W       = 3;
   localparam int PRICE_W     = 32;
   localparam int QTY_W       = 31;
   localparam int FIELDS_W    = SYM_W + 1 + PRICE_W + 2 * QTY_W;
   localparam int TDATA_W     = ((FIELDS_W + 7) / 8) * 8;
   localparam int SIDE_LSB    = SYM_W;
   localparam int PRICE_LSB   = SIDE_LSB + 1;
   localparam int SIZE_LSB    = PRICE_LSB + PRICE_W;
   localparam int ORDERS_LSB  = SIZE_LSB + QTY_W;
   localparam int RSP_TUSER_W = 2;
   localparam int TUSER_VALID = 0;
   localparam int TUSER_FULL  = 1;

   // event kinds and side codes
   localparam logic REQ_UPSERT = 1'b0;
   localparam logic REQ_DELETE = 1'b1;
   localparam logic SIDE_ASK   = 1'b0;
   localparam logic SIDE_BID   = 1'b1;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   size;
      logic [QTY_W-1:0]   orders;
   } level_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      level_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   function automatic logic [SIDX_W-1:0] side_index(logic [SYM_W-1:0] sym, logic sd);
      return SIDX_W'({sym, sd});
   endfunction

   function automatic logic [ADDR_W-1:0] entry_addr(logic [SIDX_W-1:0] sidx,
                                                    logic [CNT_W-1:0] slot);
      return ADDR_W'(sidx) * ADDR_W'(SIDE_DEPTH) + ADDR_W'(slot);
   endfunction

endpackage

`default_nettype wire

// File: hdl/plob_level_store.sv
// level store: one write port, one read port with registered read data
// depends on plob_pkg for the entry count and the level record
`default_nettype none

module plob_level_store (
   input  wire logic                   clock,
   input  wire plob_pkg::mem_wr_type   wr,
   input  wire plob_pkg::mem_rd_type   rd,
   output plob_pkg::level_type         rd_data
);
   import plob_pkg::*;

   level_type mem [NUM_ENTRIES];
   level_type rd_data_ff;

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/price_level_order_book_unit.sv
// top level of the price level order book: event sequencer, level counts, result stage
// depends on plob_pkg and plob_level_store
`default_nettype none

// Keeps a price-level book for each symbol, bids in descending and asks in ascending
// price order, up to SIDE_DEPTH levels a side. Each request beat is one parsed event:
// an upsert replaces the size and order count of the level with the same price or
// inserts a new level in sorted place, a delete removes the level with that price.
// An insert into a full side is dropped and flagged with side_full on every result
// beat of that event. After each event the whole book of the symbol streams out,
// bids best first and then asks best first, tlast on the final beat; an empty book
// gives one beat with level_valid low. Events are handled one at a time. The single
// read port of the level store is walked once to search the side, once to shift levels
// for an insert or delete, and once to read out the book.
// Level counts sit in flip-flops and clear at reset; the level store needs no clear.
// A new event is taken while the last result beat of the previous one still waits.

module price_level_order_book_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request beat
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // symbol_index[2:0], side[3], price[35:4], size[66:36], orders[97:67], zeros
   input  wire logic [plob_pkg::TDATA_W-1:0]  req_tdata,
   // req_type[0]
   input  wire logic [0:0]                    req_tuser,
   // result beat
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // book_symbol[2:0], level_side[3], level_price[35:4], level_size[66:36],
   // level_orders[97:67], zeros
   output logic [plob_pkg::TDATA_W-1:0]       rsp_tdata,
   // level_valid[0], side_full[1]
   output logic [plob_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                               rsp_tlast
);
   import plob_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MOVE,
      ST_WRITE,
      ST_COUNT,
      ST_DUMP,
      ST_EMPTY
   } state_type;

   state_type state_ff;

   // latched event
   logic               del_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic               sd_ff;
   logic [SIDX_W-1:0]  sidx_ff;
   level_type          ev_ff;
   logic               full_ff;

   // per side level counts
   logic [CNT_W-1:0]   counts_ff [NUM_SIDES];
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   other_ff;
   logic [CNT_W-1:0]   new_cnt_ff;

   // search walk
   logic [CNT_W-1:0]   s_issue_ff;
   logic               chk_valid_ff;
   logic [CNT_W-1:0]   chk_slot_ff;
   logic               match_found_ff;
   logic [CNT_W-1:0]   match_pos_ff;
   logic               ins_found_ff;
   logic [CNT_W-1:0]   ins_pos_ff;

   // shift walk
   logic [CNT_W-1:0]   mv_left_ff;
   logic [CNT_W-1:0]   mv_src_ff;
   logic               mv_up_ff;
   logic               wpend_ff;
   logic [CNT_W-1:0]   wdst_ff;
   logic               fin_wr_ff;
   logic [CNT_W-1:0]   fin_pos_ff;

   // book readout
   logic [CNT_W-1:0]   cb_ff;
   logic [TOT_W-1:0]   total_ff;
   logic [TOT_W-1:0]   n_ff;
   logic               pend_ff;
   logic               pend_side_ff;
   logic               pend_last_ff;

   // result register
   logic                    rsp_tvalid_ff;
   logic [TDATA_W-1:0]      rsp_tdata_ff;
   logic [RSP_TUSER_W-1:0]  rsp_tuser_ff;
   logic                    rsp_tlast_ff;

   // level store access
   mem_wr_type         wr;
   mem_rd_type         rd;
   level_type          rd_data;

   logic [SYM_W-1:0]   req_sym;
   logic               req_sd;
   logic               req_oor;
   logic [SIDX_W-1:0]  cnt_rd_idx;
   logic [CNT_W-1:0]   cnt_rd;
   logic               out_free;
   logic               move_out;
   logic               rsp_load;
   logic               srch_issue;
   logic               mv_issue;
   logic               dmp_issue;
   logic               dmp_bid;
   logic [CNT_W-1:0]   dmp_slot;
   logic               price_hit;
   logic               price_beyond;
   logic [CNT_W-1:0]   ins_pos;

   plob_level_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   always_comb begin
      req_sym    = req_tdata[SYM_W-1:0];
      req_sd     = req_tdata[SIDE_LSB];
      req_oor    = ({29'd0, req_sym} >= 32'(NUM_SYMBOLS));
      // one count read a cycle: the event side at accept, the other side while searching
      cnt_rd_idx = (state_ff == ST_IDLE) ? side_index(req_sym, req_sd)
                                         : {sidx_ff[SIDX_W-1:1], ~sidx_ff[0]};
      cnt_rd     = counts_ff[cnt_rd_idx];

      out_free   = !rsp_tvalid_ff || rsp_tready;
      move_out   = pend_ff && out_free;
      // result register takes a new beat
      rsp_load   = ((state_ff == ST_DUMP) && move_out) || ((state_ff == ST_EMPTY) && out_free);
      srch_issue = (state_ff == ST_SEARCH) && (s_issue_ff < cnt_ff);
      mv_issue   = (state_ff == ST_MOVE) && (mv_left_ff != '0);
      dmp_issue  = (state_ff == ST_DUMP) && (n_ff < total_ff) && (!pend_ff || move_out);
      dmp_bid    = n_ff < TOT_W'(cb_ff);
      dmp_slot   = dmp_bid ? CNT_W'(n_ff) : CNT_W'(n_ff - TOT_W'(cb_ff));

      price_hit    = rd_data.price == ev_ff.price;
      price_beyond = sd_ff ? (rd_data.price < ev_ff.price) : (rd_data.price > ev_ff.price);
      ins_pos      = ins_found_ff ? ins_pos_ff : cnt_ff;

      rd.en = srch_issue || mv_issue || dmp_issue;
      priority if (mv_issue) begin
         rd.addr = entry_addr(sidx_ff, mv_src_ff);
      end else if (dmp_issue) begin
         rd.addr = entry_addr(side_index(sym_ff, dmp_bid ? SIDE_BID : SIDE_ASK), dmp_slot);
      end else begin
         rd.addr = entry_addr(sidx_ff, s_issue_ff);
      end

      priority if ((state_ff == ST_MOVE) && wpend_ff) begin
         wr.en   = 1'b1;
         wr.addr = entry_addr(sidx_ff, wdst_ff);
         wr.data = rd_data;
      end else if (state_ff == ST_WRITE) begin
         wr.en   = 1'b1;
         wr.addr = entry_addr(sidx_ff, fin_pos_ff);
         wr.data = ev_ff;
      end else begin
         wr.en   = 1'b0;
         wr.addr = '0;
         wr.data = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         pend_ff       <= 1'b0;
         chk_valid_ff  <= 1'b0;
         wpend_ff      <= 1'b0;
         full_ff       <= 1'b0;
         for (int i = 0; i < NUM_SIDES; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  del_ff          <= req_tuser[0] == REQ_DELETE;
                  sym_ff          <= req_sym;
                  sd_ff           <= req_sd;
                  sidx_ff         <= side_index(req_sym, req_sd);
                  ev_ff.price     <= req_tdata[PRICE_LSB +: PRICE_W];
                  ev_ff.size      <= req_tdata[SIZE_LSB +: QTY_W];
                  ev_ff.orders    <= req_tdata[ORDERS_LSB +: QTY_W];
                  full_ff         <= 1'b0;
                  cnt_ff          <= cnt_rd;
                  s_issue_ff      <= '0;
                  chk_valid_ff    <= 1'b0;
                  match_found_ff  <= 1'b0;
                  ins_found_ff    <= 1'b0;
                  // out of range symbol: no state change, one empty beat
                  state_ff        <= req_oor ? ST_EMPTY : ST_SEARCH;
               end
            end

            ST_SEARCH: begin
               other_ff <= cnt_rd;
               // issue slot k, compare it the cycle after
               chk_valid_ff <= srch_issue;
               chk_slot_ff  <= s_issue_ff;
               if (srch_issue) begin
                  s_issue_ff <= s_issue_ff + CNT_W'(1);
               end
               if (chk_valid_ff) begin
                  if (!match_found_ff && price_hit) begin
                     match_found_ff <= 1'b1;
                     match_pos_ff   <= chk_slot_ff;
                  end
                  if (!ins_found_ff && price_beyond) begin
                     ins_found_ff <= 1'b1;
                     ins_pos_ff   <= chk_slot_ff;
                  end
               end
               if (!srch_issue && !chk_valid_ff) begin
                  wpend_ff  <= 1'b0;
                  priority if (del_ff && match_found_ff) begin
                     // close the gap: each later level moves one slot down
                     mv_left_ff <= cnt_ff - match_pos_ff - CNT_W'(1);
                     mv_src_ff  <= match_pos_ff + CNT_W'(1);
                     mv_up_ff   <= 1'b0;
                     fin_wr_ff  <= 1'b0;
                     new_cnt_ff <= cnt_ff - CNT_W'(1);
                     state_ff   <= ST_MOVE;
                  end else if (del_ff) begin
                     new_cnt_ff <= cnt_ff;
                     state_ff   <= ST_COUNT;
                  end else if (match_found_ff) begin
                     fin_pos_ff <= match_pos_ff;
                     new_cnt_ff <= cnt_ff;
                     state_ff   <= ST_WRITE;
                  end else if (32'(cnt_ff) >= 32'(SIDE_DEPTH)) begin
                     full_ff    <= 1'b1;
                     new_cnt_ff <= cnt_ff;
                     state_ff   <= ST_COUNT;
                  end else begin
                     // open a gap: levels from the end down to the insert slot move up
                     mv_left_ff <= cnt_ff - ins_pos;
                     mv_src_ff  <= cnt_ff - CNT_W'(1);
                     mv_up_ff   <= 1'b1;
                     fin_wr_ff  <= 1'b1;
                     fin_pos_ff <= ins_pos;
                     new_cnt_ff <= cnt_ff + CNT_W'(1);
                     state_ff   <= ST_MOVE;
                  end
               end
            end

            ST_MOVE: begin
               // read source now, write it to its new slot next cycle
               wpend_ff <= mv_issue;
               wdst_ff  <= mv_up_ff ? mv_src_ff + CNT_W'(1) : mv_src_ff - CNT_W'(1);
               if (mv_issue) begin
                  mv_left_ff <= mv_left_ff - CNT_W'(1);
                  mv_src_ff  <= mv_up_ff ? mv_src_ff - CNT_W'(1) : mv_src_ff + CNT_W'(1);
               end
               if (!mv_issue && !wpend_ff) begin
                  state_ff <= fin_wr_ff ? ST_WRITE : ST_COUNT;
               end
            end

            ST_WRITE: begin
               state_ff <= ST_COUNT;
            end

            ST_COUNT: begin
               counts_ff[sidx_ff] <= new_cnt_ff;
               cb_ff    <= sd_ff ? new_cnt_ff : other_ff;
               total_ff <= TOT_W'(new_cnt_ff) + TOT_W'(other_ff);
               n_ff     <= '0;
               pend_ff  <= 1'b0;
               state_ff <= ((new_cnt_ff == '0) && (other_ff == '0)) ? ST_EMPTY : ST_DUMP;
            end

            ST_DUMP: begin
               if (dmp_issue) begin
                  n_ff         <= n_ff + TOT_W'(1);
                  pend_ff      <= 1'b1;
                  pend_side_ff <= dmp_bid ? SIDE_BID : SIDE_ASK;
                  pend_last_ff <= n_ff == total_ff - TOT_W'(1);
               end else if (move_out) begin
                  pend_ff <= 1'b0;
               end
               if (move_out) begin
                  rsp_tdata_ff  <= TDATA_W'({rd_data.orders, rd_data.size, rd_data.price,
                                             pend_side_ff, sym_ff});
                  rsp_tuser_ff  <= {full_ff, 1'b1};
                  rsp_tlast_ff  <= pend_last_ff;
                  if (pend_last_ff) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end

            ST_EMPTY: begin
               if (out_free) begin
                  rsp_tdata_ff  <= TDATA_W'(sym_ff);
                  rsp_tuser_ff  <= {full_ff, 1'b0};
                  rsp_tlast_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // a shift never writes the entry it reads in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr.en && rd.en) |-> (wr.addr != rd.addr))
      else $error("level store read and write hit the same entry");

   // a side never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT) |-> (32'(new_cnt_ff) <= 32'(SIDE_DEPTH)))
      else $error("side level count above capacity");

   // search never walks past the side's count
   a_search_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (s_issue_ff <= cnt_ff))
      else $error("search issued beyond side count");

   // readout never issues more beats than the book holds
   a_dump_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> (n_ff <= total_ff))
      else $error("readout issued beyond book size");

   // the final beat of a dump returns the sequencer to idle
   a_dump_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && move_out && pend_last_ff) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after last beat");

endmodule

`default_nettype wire

// File: sim/tb.sv
// testbench for price_level_order_book_unit: directed and random book events, per-beat check
// depends on plob_pkg and the rtl of price_level_order_book_unit

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import plob_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int POOL_SIZE       = 20;
   localparam int ITEMS_PER_PHASE = 102;
   localparam int REPORT_LIMIT    = 10;

   // one emitted book line as the block should present it
   typedef struct {
      logic [SYM_W-1:0] sym;
      logic             sd;
      level_type        lvl;
      logic             valid;
      logic             full;
      logic             last;
   } book_beat_type;

   // shadow copy of every book plus the queue of book lines still owed by the block
   class book_scoreboard;
      level_type     levels[NUM_SIDES][SIDE_DEPTH];
      int unsigned   counts[NUM_SIDES];
      book_beat_type expected_beats[$];
      int            errors       = 0;
      int            beats_seen   = 0;
      int            events       = 0;
      int            deletes      = 0;
      int            full_events  = 0;
      int            empty_books  = 0;

      function void flag(string what);
         errors++;
         if (errors <= REPORT_LIMIT) $display("%s", what);
      endfunction

      function void match(string name, logic [31:0] exp_v, logic [31:0] got_v);
         if (exp_v !== got_v)
            flag($sformatf("beat %0d %s: expected %h, got %h", beats_seen, name, exp_v, got_v));
      endfunction

      // apply one accepted event to the shadow book and queue the book dump it causes
      function void note_event(logic kind, logic [SYM_W-1:0] sym, logic sd, level_type ev);
         int            sidx, cnt, pos, i, k, n, total, s;
         logic          full;
         logic          this_side;
         logic          past;
         book_beat_type beat;
         sidx = int'(sym) * 2 + int'(sd);
         cnt  = counts[sidx];
         full = 1'b0;
         events++;
         if (kind == REQ_DELETE) deletes++;
         pos = 0;
         while (pos < cnt && levels[sidx][pos].price != ev.price) pos++;
         if (kind == REQ_DELETE) begin
            // close the gap left by the removed level
            if (pos < cnt) begin
               for (i = pos; i < cnt - 1; i++) levels[sidx][i] = levels[sidx][i + 1];
               cnt--;
            end
         end else if (pos < cnt) begin
            levels[sidx][pos].size   = ev.size;
            levels[sidx][pos].orders = ev.orders;
         end else if (cnt >= SIDE_DEPTH) begin
            full = 1'b1;
            full_events++;
         end else begin
            // bids best first means descending, asks ascending
            pos = 0;
            while (pos < cnt) begin
               past = (sd == SIDE_BID) ? (levels[sidx][pos].price < ev.price)
                                       : (levels[sidx][pos].price > ev.price);
               if (past) break;
               pos++;
            end
            for (i = cnt; i > pos; i--) levels[sidx][i] = levels[sidx][i - 1];
            levels[sidx][pos] = ev;
            cnt++;
         end
         counts[sidx] = cnt;

         total = counts[int'(sym) * 2] + counts[int'(sym) * 2 + 1];
         beat.sym  = sym;
         beat.full = full;
         if (total == 0) begin
            empty_books++;
            beat.sd    = SIDE_ASK;
            beat.lvl   = '0;
            beat.valid = 1'b0;
            beat.last  = 1'b1;
            expected_beats = {expected_beats, beat};
         end else begin
            n = 0;
            for (k = 0; k < 2; k++) begin
               this_side = (k == 0) ? SIDE_BID : SIDE_ASK;
               s = int'(sym) * 2 + int'(this_side);
               for (i = 0; i < counts[s]; i++) begin
                  beat.sd    = this_side;
                  beat.lvl   = levels[s][i];
                  beat.valid = 1'b1;
                  beat.last  = (n == total - 1);
                  expected_beats = {expected_beats, beat};
                  n++;
               end
            end
         end
      endfunction

      function void check_beat(book_beat_type got);
         book_beat_type want;
         beats_seen++;
         if (expected_beats.size() == 0) begin
            flag($sformatf("beat %0d arrived with nothing outstanding", beats_seen));
            return;
         end
         want = expected_beats.pop_front();
         match("book_symbol",  32'(want.sym),        32'(got.sym));
         match("level_side",   32'(want.sd),         32'(got.sd));
         match("level_price",  want.lvl.price,       got.lvl.price);
         match("level_size",   32'(want.lvl.size),   32'(got.lvl.size));
         match("level_orders", 32'(want.lvl.orders), 32'(got.lvl.orders));
         match("level_valid",  32'(want.valid),      32'(got.valid));
         match("side_full",    32'(want.full),       32'(got.full));
         match("tlast",        32'(want.last),       32'(got.last));
      endfunction

      function void flush_leftovers();
         if (expected_beats.size() != 0)
            flag($sformatf("%0d book beats never arrived", expected_beats.size()));
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata   = '0;
   logic [0:0]         req_tuser   = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic               rsp_tlast;

   book_scoreboard sb = new();

   // idle and stall odds in percent, changed per phase
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int cycle_count   = 0;

   logic [PRICE_W-1:0] price_pool[POOL_SIZE];

   price_level_order_book_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side backpressure, changes only on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // every accepted result beat goes straight to the scoreboard
   always @(posedge clock) begin
      book_beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sym        = rsp_tdata[SYM_W-1:0];
         got.sd         = rsp_tdata[SIDE_LSB];
         got.lvl.price  = rsp_tdata[PRICE_LSB +: PRICE_W];
         got.lvl.size   = rsp_tdata[SIZE_LSB +: QTY_W];
         got.lvl.orders = rsp_tdata[ORDERS_LSB +: QTY_W];
         got.valid      = rsp_tuser[TUSER_VALID];
         got.full       = rsp_tuser[TUSER_FULL];
         got.last       = rsp_tlast;
         sb.check_beat(got);
      end
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  sb.expected_beats.size());
         $display("[price_level_order_book_unit] ERROR");
         $finish;
      end
   end

   // present one event beat, holding it until the block takes it
   task automatic send_event(input logic kind, input logic [SYM_W-1:0] sym, input logic sd,
                             input level_type ev);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= TDATA_W'({ev.orders, ev.size, ev.price, sd, sym});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_event(kind, sym, sd, ev);
   endtask

   function automatic logic [QTY_W-1:0] pick_qty();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return QTY_W'($urandom());
      endcase
   endfunction

   // mostly a few hot symbols and a small price pool so sides fill up, updates hit
   // existing levels and deletes find their price; the rest is plain noise
   task automatic send_random_event();
      logic             kind;
      logic [SYM_W-1:0] sym;
      logic             sd;
      level_type        ev;
      int               sidx;
      sym  = $urandom_range(1) ? SYM_W'($urandom_range(1)) : SYM_W'($urandom_range(7));
      sd   = 1'($urandom_range(1));
      sidx = int'(sym) * 2 + int'(sd);
      kind = ($urandom_range(99) < 32) ? REQ_DELETE : REQ_UPSERT;
      ev.price = price_pool[$urandom_range(POOL_SIZE - 1)];
      if (kind == REQ_DELETE && sb.counts[sidx] != 0 && $urandom_range(3) != 0)
         ev.price = sb.levels[sidx][$urandom_range(sb.counts[sidx] - 1)].price;
      else if ($urandom_range(9) == 0)
         ev.price = $urandom();
      ev.size   = pick_qty();
      ev.orders = pick_qty();
      send_event(kind, sym, sd, ev);
   endtask

   initial begin
      level_type ev;
      int        i;
      int        phase;

      price_pool[0] = '0;
      price_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) price_pool[i] = $urandom();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: delete on an empty book gives the empty book line
      send_event(REQ_DELETE, 3'd0, SIDE_ASK, '{price: 32'd5, size: '1, orders: '1});
      // extreme prices and quantities, insert then in-place update
      send_event(REQ_UPSERT, 3'd0, SIDE_ASK, '{price: '0, size: '0, orders: '0});
      send_event(REQ_UPSERT, 3'd0, SIDE_BID, '{price: '1, size: '1, orders: '1});
      send_event(REQ_UPSERT, 3'd0, SIDE_BID, '{price: '1, size: 31'd1, orders: '0});
      // remove both levels, last one leaves the book empty
      send_event(REQ_DELETE, 3'd0, SIDE_BID, '{price: '1, size: '0, orders: '0});
      send_event(REQ_DELETE, 3'd0, SIDE_ASK, '{price: '0, size: '0, orders: '0});
      // fill the bid side of the top symbol in scrambled order
      for (i = 0; i < SIDE_DEPTH; i++) begin
         ev.price  = PRICE_W'(((i * 7) % 16) * 32'h1111_1111);
         ev.size   = QTY_W'(i + 1);
         ev.orders = pick_qty();
         send_event(REQ_UPSERT, 3'd7, SIDE_BID, ev);
      end
      // new price on a full side is dropped, existing price still updates
      send_event(REQ_UPSERT, 3'd7, SIDE_BID, '{price: 32'h0800_0000, size: 31'd9, orders: 31'd9});
      send_event(REQ_UPSERT, 3'd7, SIDE_BID, '{price: 32'h7777_7777, size: '1, orders: 31'd3});
      send_event(REQ_DELETE, 3'd7, SIDE_BID, '{price: 32'hFFFF_FFFF, size: '0, orders: '0});

      // random part in four pressure phases
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 63; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 63; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         for (i = 0; i < ITEMS_PER_PHASE; i++) send_random_event();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.flush_leftovers();

      $display("%0d events (%0d deletes), %0d book beats checked", sb.events, sb.deletes,
               sb.beats_seen);
      $display("%0d dropped inserts on full sides, %0d empty books, %0d failures",
               sb.full_events, sb.empty_books, sb.errors);
      if (sb.errors == 0) begin
         $display("[price_level_order_book_unit] OK");
      end else begin
         $display("[price_level_order_book_unit] ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/plob_pkg.sv
hdl/plob_level_store.sv
hdl/price_level_order_book_unit.sv
sim/tb.sv
